@@ rtl/core/bitcrush_resample_bezier_core_assert.svh @@
// Assertion macros used by the bitcrusher serial multiplier
`ifndef BITCRUSH_RESAMPLE_BEZIER_CORE_ASSERT_SVH
`define BITCRUSH_RESAMPLE_BEZIER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define BCRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define BCRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bcrb_pkg.sv @@
// Shared constants, types and codes for the bitcrusher / resampler core
package bcrb_pkg;

    // Default datapath sizes
    localparam int BCRB_SAMPLE_BITS     = 24;
    localparam int BCRB_PHASE_FRAC_BITS = 16;

    // Quantiser depth register
    localparam int BCRB_DEPTH_W   = 5;
    localparam int BCRB_DEPTH_MAX = 16;

    // Mix register, Q10
    localparam int BCRB_MIX_W    = 12;
    localparam int BCRB_MIX_FRAC = 10;
    localparam int BCRB_GAIN_W   = BCRB_MIX_FRAC + 1;
    localparam logic [BCRB_MIX_W-1:0] BCRB_MIX_ONE  = BCRB_MIX_W'(1 << BCRB_MIX_FRAC);
    localparam logic [BCRB_MIX_W-1:0] BCRB_MIX_TWO  = BCRB_MIX_W'(2 << BCRB_MIX_FRAC);
    localparam int                    BCRB_MIX_HALF = 1 << (BCRB_MIX_FRAC - 1);

    // Minimum phase step is 0.0005 of a full cycle, rounded up
    localparam int BCRB_RATE_MIN_NUM = 5;
    localparam int BCRB_RATE_MIN_DEN = 10000;

    // Configuration port
    localparam int BCRB_ADDR_W = 4;
    localparam int BCRB_APB_W  = 32;

    typedef enum logic [1:0] {
        REG_RATE_STEP = 2'd0,
        REG_BIT_DEPTH = 2'd1,
        REG_WET_MIX   = 2'd2
    } t_reg_idx;

    // Sequencer states: three passes through the serial multiplier
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ISSUE_AVG,
        ST_WAIT_AVG,
        ST_POST_AVG,
        ST_ISSUE_BLEND,
        ST_WAIT_BLEND,
        ST_POST_BLEND,
        ST_ISSUE_MIX,
        ST_WAIT_MIX,
        ST_POST_MIX
    } t_state;

    // Status of the serial multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

@@ rtl/core/bcrb_front.sv @@
// Quantiser, phase accumulator and three-entry sample history
module bcrb_front
    import bcrb_pkg::*;
#(
    parameter int SAMPLE_BITS     = BCRB_SAMPLE_BITS,
    parameter int PHASE_FRAC_BITS = BCRB_PHASE_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [PHASE_FRAC_BITS:0]      i_rate,
    input  logic [BCRB_DEPTH_W-1:0]       i_depth,
    output logic [PHASE_FRAC_BITS:0]      o_phase,
    output logic signed [SAMPLE_BITS-1:0] o_hist_a,
    output logic signed [SAMPLE_BITS-1:0] o_hist_b,
    output logic signed [SAMPLE_BITS-1:0] o_hist_c
);

    localparam int S     = SAMPLE_BITS;
    localparam int P     = PHASE_FRAC_BITS;
    localparam int B_MAX = (S - 1 < BCRB_DEPTH_MAX) ? S - 1 : BCRB_DEPTH_MAX;
    localparam int SH_W  = $clog2(S);
    localparam int RATE_MIN_I =
        ((1 << P) * BCRB_RATE_MIN_NUM + BCRB_RATE_MIN_DEN - 1) / BCRB_RATE_MIN_DEN;
    localparam logic [P:0]   RATE_MIN = (P + 1)'(RATE_MIN_I);
    localparam logic [P:0]   PH_ONE   = {1'b1, {P{1'b0}}};
    localparam logic [P+1:0] PH_ONE_X = {2'b01, {P{1'b0}}};
    localparam logic [S-1:0] S_MAX    = {1'b0, {(S - 1){1'b1}}};
    localparam logic [S-1:0] S_MIN    = {1'b1, {(S - 1){1'b0}}};

    logic [BCRB_DEPTH_W-1:0] depth;
    logic [BCRB_DEPTH_W:0]   depth_x2;
    logic [SH_W-1:0]         q_shift;
    logic [SH_W-1:0]         ofs_exp;
    logic                    ofs_on;
    logic [S:0]              ofs;
    logic [S:0]              v;
    logic [S:0]              vq;
    logic [S-1:0]            q;
    logic [P:0]              rate;
    logic [P+1:0]            ph_sum;
    logic [P+1:0]            ph_wrapped;
    logic                    wrap;
    logic [P:0]              n_phase;

    logic [P:0]              r_phase;
    logic [S-1:0]            r_hist_a;
    logic [S-1:0]            r_hist_b;
    logic [S-1:0]            r_hist_c;

    // Quantiser: add half of the squared step, clear the dropped bits, saturate
    always_comb begin
        if (i_depth == '0) begin
            depth = BCRB_DEPTH_W'(1);
        end else if (i_depth > BCRB_DEPTH_W'(B_MAX)) begin
            depth = BCRB_DEPTH_W'(B_MAX);
        end else begin
            depth = i_depth;
        end
        depth_x2 = {depth, 1'b0};
        q_shift  = SH_W'(S - 1) - SH_W'(depth);
        // offset falls below one LSB at high depths
        ofs_on   = (depth_x2 <= (BCRB_DEPTH_W + 1)'(S - 2));
        ofs_exp  = SH_W'(S - 2) - SH_W'(depth_x2);
        ofs      = ofs_on ? ((S + 1)'(1) << ofs_exp) : '0;
        v        = {i_sample[S-1], i_sample} + ofs;
        vq       = v & ({(S + 1){1'b1}} << q_shift);
        if (vq[S] != vq[S-1]) begin
            q = vq[S] ? S_MIN : S_MAX;
        end else begin
            q = vq[S-1:0];
        end
    end

    // Phase accumulator with clamped step
    always_comb begin
        if (i_rate < RATE_MIN) begin
            rate = RATE_MIN;
        end else if (i_rate > PH_ONE) begin
            rate = PH_ONE;
        end else begin
            rate = i_rate;
        end
        ph_sum     = {1'b0, r_phase} + {1'b0, rate};
        wrap       = (ph_sum > PH_ONE_X);
        ph_wrapped = ph_sum - PH_ONE_X;
        n_phase    = wrap ? ph_wrapped[P:0] : ph_sum[P:0];
    end

    // Phase update once per accepted item; the history shifts only when the phase wraps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ONE;
            r_hist_a <= '0;
            r_hist_b <= '0;
            r_hist_c <= '0;
        end else if (i_load) begin
            r_phase <= n_phase;
            if (wrap) begin
                r_hist_c <= r_hist_b;
                r_hist_b <= r_hist_a;
                r_hist_a <= q;
            end
        end
    end

    assign o_phase  = r_phase;
    assign o_hist_a = r_hist_a;
    assign o_hist_b = r_hist_b;
    assign o_hist_c = r_hist_c;

endmodule

@@ rtl/core/bcrb_sermul.sv @@
// Two-lane bit-serial multiplier, signed multiplicand by unsigned multiplier
`include "bitcrush_resample_bezier_core_assert.svh"

module bcrb_sermul
    import bcrb_pkg::*;
#(
    parameter int MCAND_W = BCRB_SAMPLE_BITS + 1,
    parameter int MULT_W  = BCRB_PHASE_FRAC_BITS + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [MCAND_W-1:0]          i_mcand_a,
    input  logic [MCAND_W-1:0]          i_mcand_b,
    input  logic [MULT_W-1:0]           i_mult_a,
    input  logic [MULT_W-1:0]           i_mult_b,
    output t_mul_stat                   o_stat,
    output logic [MCAND_W+MULT_W-1:0]   o_prod_a,
    output logic [MCAND_W+MULT_W-1:0]   o_prod_b
);

    localparam int ACC_W = MCAND_W + MULT_W;
    localparam int CNT_W = $clog2(MULT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MULT_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MCAND_W-1:0] r_mc_a;
    logic [MCAND_W-1:0] r_mc_b;
    logic [ACC_W-1:0]   r_acc_a;
    logic [ACC_W-1:0]   r_acc_b;

    logic [MCAND_W:0]   sum_a;
    logic [MCAND_W:0]   sum_b;
    logic [ACC_W-1:0]   n_acc_a;
    logic [ACC_W-1:0]   n_acc_b;

    // One multiplier bit per cycle: add on the LSB, shift the whole word right
    always_comb begin
        sum_a = {r_acc_a[ACC_W-1], r_acc_a[ACC_W-1:MULT_W]}
              + (r_acc_a[0] ? {r_mc_a[MCAND_W-1], r_mc_a} : '0);
        sum_b = {r_acc_b[ACC_W-1], r_acc_b[ACC_W-1:MULT_W]}
              + (r_acc_b[0] ? {r_mc_b[MCAND_W-1], r_mc_b} : '0);
        n_acc_a = {sum_a, r_acc_a[MULT_W-1:1]};
        n_acc_b = {sum_b, r_acc_b[MULT_W-1:1]};
    end

    // Step counter and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and accumulator shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mc_a  <= i_mcand_a;
            r_mc_b  <= i_mcand_b;
            r_acc_a <= {{MCAND_W{1'b0}}, i_mult_a};
            r_acc_b <= {{MCAND_W{1'b0}}, i_mult_b};
        end else if (r_busy) begin
            r_acc_a <= n_acc_a;
            r_acc_b <= n_acc_b;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod_a    = r_acc_a;
    assign o_prod_b    = r_acc_b;

    `BCRB_ASSERT_IMP(a_start_when_idle, i_clk, i_rst_n, i_start, !r_busy && !r_done, "mul restarted while running")
    `BCRB_ASSERT_NXT(a_start_runs, i_clk, i_rst_n, i_start, r_busy && (r_cnt == '0), "mul did not start")
    `BCRB_ASSERT_NXT(a_last_step_done, i_clk, i_rst_n, r_busy && (r_cnt == CNT_LAST), r_done && !r_busy, "mul did not finish")
    `BCRB_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "mul done held over")

endmodule

@@ rtl/core/bitcrush_resample_bezier_core.sv @@
// Each item makes three passes of PHASE_FRAC_BITS+1 steps through the shared bit-serial
// multiplier; a new item is taken only in the idle state, after the result is loaded.
// A finished result waits in the output register; the next item is taken meanwhile.
// Reset is synchronous, active low: registers to defaults, phase to 1.0, history to zero.
// Top level of the bitcrusher with sample-hold resampling and Bezier smoothing
module bitcrush_resample_bezier_core
    import bcrb_pkg::*;
#(
    parameter int SAMPLE_BITS     = BCRB_SAMPLE_BITS,
    parameter int PHASE_FRAC_BITS = BCRB_PHASE_FRAC_BITS,
    localparam int DATA_W         = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DATA_W-1:0]      s_axis_tdata,   // [SAMPLE_BITS-1:0] sample_in
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [DATA_W-1:0]      m_axis_tdata,   // [SAMPLE_BITS-1:0] sample_out
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [BCRB_ADDR_W-1:0] paddr,
    input  logic [BCRB_APB_W-1:0]  pwdata,
    output logic [BCRB_APB_W-1:0]  prdata,
    output logic                   pready
);

    localparam int S      = SAMPLE_BITS;
    localparam int P      = PHASE_FRAC_BITS;
    localparam int MC_W   = S + 1;
    localparam int MUL_W  = P + 1;
    localparam int PROD_W = MC_W + MUL_W;
    localparam int Y_W    = PROD_W - BCRB_MIX_FRAC;
    localparam logic [PROD_W-1:0] PH_HALF  = PROD_W'(1) << (P - 1);
    localparam logic [PROD_W-1:0] MIX_HALF = PROD_W'(BCRB_MIX_HALF);
    localparam logic [S-1:0]      S_MAX    = {1'b0, {(S - 1){1'b1}}};
    localparam logic [S-1:0]      S_MIN    = {1'b1, {(S - 1){1'b0}}};

    // Configuration registers
    logic [P:0]              r_rate_step;
    logic [BCRB_DEPTH_W-1:0] r_bit_depth;
    logic [BCRB_MIX_W-1:0]   r_wet_mix;

    // Sequencer and datapath registers
    t_state                  r_state;
    t_state                  n_state;
    logic [S-1:0]            r_x;
    logic [S-1:0]            r_cbl;
    logic [S-1:0]            r_bal;
    logic [S-1:0]            r_cb;
    logic                    r_out_valid;
    logic [S-1:0]            r_out_data;

    logic [S-1:0]            n_cbl;
    logic [S-1:0]            n_bal;
    logic [S-1:0]            n_cb;
    logic [S-1:0]            n_out;

    logic                    cfg_wr;
    logic                    in_acc;
    logic                    out_free;
    logic                    out_load;
    logic                    mul_start;
    logic [MC_W-1:0]         mc_a;
    logic [MC_W-1:0]         mc_b;
    logic [MUL_W-1:0]        ml_a;
    logic [MUL_W-1:0]        ml_b;
    t_mul_stat               mul_stat;
    logic [PROD_W-1:0]       prod_a;
    logic [PROD_W-1:0]       prod_b;

    logic [P:0]              phase;
    logic [S-1:0]            hist_a;
    logic [S-1:0]            hist_b;
    logic [S-1:0]            hist_c;

    logic [BCRB_GAIN_W-1:0]  wet;
    logic [BCRB_GAIN_W-1:0]  dry;
    logic [BCRB_MIX_W-1:0]   dry_full;

    logic [PROD_W-1:0]       rnd_a;
    logic [PROD_W-1:0]       rnd_b;
    logic [S:0]              avg_a;
    logic [S:0]              avg_b;
    logic [S:0]              blend_base;
    logic [PROD_W-1:0]       blend_sum;
    logic [PROD_W-1:0]       mix_sum;
    logic [Y_W-1:0]          y_full;
    logic [Y_W-S:0]          y_top;

    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // Register file write and read-back
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_step <= {1'b1, {P{1'b0}}};
            r_bit_depth <= BCRB_DEPTH_W'(BCRB_DEPTH_MAX);
            r_wet_mix   <= BCRB_MIX_ONE;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[BCRB_ADDR_W-1:2]))
                REG_RATE_STEP: begin
                    r_rate_step <= pwdata[P:0];
                end
                REG_BIT_DEPTH: begin
                    r_bit_depth <= pwdata[BCRB_DEPTH_W-1:0];
                end
                REG_WET_MIX: begin
                    r_wet_mix <= pwdata[BCRB_MIX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[BCRB_ADDR_W-1:2]))
            REG_RATE_STEP: prdata = BCRB_APB_W'(r_rate_step);
            REG_BIT_DEPTH: prdata = BCRB_APB_W'(r_bit_depth);
            REG_WET_MIX:   prdata = BCRB_APB_W'(r_wet_mix);
            default:       prdata = '0;
        endcase
    end

    // Quantiser, phase and history
    bcrb_front #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_acc),
        .i_sample (s_axis_tdata[S-1:0]),
        .i_rate   (r_rate_step),
        .i_depth  (r_bit_depth),
        .o_phase  (phase),
        .o_hist_a (hist_a),
        .o_hist_b (hist_b),
        .o_hist_c (hist_c)
    );

    // Shared serial multiplier
    bcrb_sermul #(
        .MCAND_W (MC_W),
        .MULT_W  (MUL_W)
    ) u_sermul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand_a (mc_a),
        .i_mcand_b (mc_b),
        .i_mult_a  (ml_a),
        .i_mult_b  (ml_b),
        .o_stat    (mul_stat),
        .o_prod_a  (prod_a),
        .o_prod_b  (prod_b)
    );

    // Wet and dry gains, each capped at 1.0
    always_comb begin
        if (r_wet_mix > BCRB_MIX_ONE) begin
            wet = BCRB_GAIN_W'(BCRB_MIX_ONE);
        end else begin
            wet = r_wet_mix[BCRB_GAIN_W-1:0];
        end
        dry_full = BCRB_MIX_TWO - r_wet_mix;
        if (r_wet_mix >= BCRB_MIX_TWO) begin
            dry = '0;
        end else if (dry_full > BCRB_MIX_ONE) begin
            dry = BCRB_GAIN_W'(BCRB_MIX_ONE);
        end else begin
            dry = dry_full[BCRB_GAIN_W-1:0];
        end
    end

    // Post-processing of each multiplier pass
    always_comb begin
        // outer control points: lerp = low + round(diff * t)
        rnd_a = prod_a + PH_HALF;
        rnd_b = prod_b + PH_HALF;
        avg_a = {hist_c[S-1], hist_c} + rnd_a[P+S:P];
        avg_b = {hist_b[S-1], hist_b} + rnd_b[P+S:P];
        n_cbl = avg_a[S-1:0];
        n_bal = avg_b[S-1:0];

        // middle point: (B + cbl + 1) * 2^P + (bal - cbl) * t, over 2^(P+1)
        blend_base = {hist_b[S-1], hist_b}
                   + {r_cbl[S-1], r_cbl} + (S + 1)'(1);
        blend_sum  = {blend_base[S], blend_base, {P{1'b0}}} + prod_a;
        n_cb       = blend_sum[P+S:P+1];

        // mix and saturate
        mix_sum = prod_a + prod_b + MIX_HALF;
        y_full  = mix_sum[PROD_W-1:BCRB_MIX_FRAC];
        y_top   = y_full[Y_W-1:S-1];
        if ((&y_top) || !(|y_top)) begin
            n_out = y_full[S-1:0];
        end else begin
            n_out = y_full[Y_W-1] ? S_MIN : S_MAX;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_ISSUE_AVG;
                end
            end
            ST_ISSUE_AVG:   n_state = ST_WAIT_AVG;
            ST_WAIT_AVG: begin
                if (mul_stat.done) begin
                    n_state = ST_POST_AVG;
                end
            end
            ST_POST_AVG:    n_state = ST_ISSUE_BLEND;
            ST_ISSUE_BLEND: n_state = ST_WAIT_BLEND;
            ST_WAIT_BLEND: begin
                if (mul_stat.done) begin
                    n_state = ST_POST_BLEND;
                end
            end
            ST_POST_BLEND:  n_state = ST_ISSUE_MIX;
            ST_ISSUE_MIX:   n_state = ST_WAIT_MIX;
            ST_WAIT_MIX: begin
                if (mul_stat.done) begin
                    n_state = ST_POST_MIX;
                end
            end
            ST_POST_MIX: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:        n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs and multiplier operands
    always_comb begin
        s_axis_tready = 1'b0;
        mul_start     = 1'b0;
        out_load      = 1'b0;
        mc_a          = '0;
        mc_b          = '0;
        ml_a          = '0;
        ml_b          = '0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_ISSUE_AVG: begin
                mul_start = 1'b1;
                mc_a      = {hist_b[S-1], hist_b} - {hist_c[S-1], hist_c};
                mc_b      = {hist_a[S-1], hist_a} - {hist_b[S-1], hist_b};
                ml_a      = phase;
                ml_b      = phase;
            end
            ST_ISSUE_BLEND: begin
                mul_start = 1'b1;
                mc_a      = {r_bal[S-1], r_bal} - {r_cbl[S-1], r_cbl};
                ml_a      = phase;
            end
            ST_ISSUE_MIX: begin
                mul_start = 1'b1;
                mc_a      = {r_cb[S-1], r_cb};
                ml_a      = MUL_W'(wet);
                mc_b      = {r_x[S-1], r_x};
                ml_b      = MUL_W'(dry);
            end
            ST_POST_MIX: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= s_axis_tdata[S-1:0];
        end
        if (r_state == ST_POST_AVG) begin
            r_cbl <= n_cbl;
            r_bal <= n_bal;
        end
        if (r_state == ST_POST_BLEND) begin
            r_cb <= n_cb;
        end
        if (out_load) begin
            r_out_data <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DATA_W'(r_out_data);

endmodule

@@ tb/sv/bitcrush_resample_bezier_core_test.sv @@
// Self-checking testbench for the bitcrusher / resampler / Bezier smoother core
`timescale 1ns / 1ps

module bitcrush_resample_bezier_core_test;
    import bcrb_pkg::*;

    localparam int     SW        = BCRB_SAMPLE_BITS;
    localparam int     PF        = BCRB_PHASE_FRAC_BITS;
    localparam int     DATA_W    = ((SW + 7) / 8) * 8;
    localparam int     DEPTH_TOP = (SW - 1 < BCRB_DEPTH_MAX) ? SW - 1 : BCRB_DEPTH_MAX;
    localparam longint PH_ONE    = longint'(1) << PF;
    localparam longint RATE_FLOOR =
        (PH_ONE * BCRB_RATE_MIN_NUM + BCRB_RATE_MIN_DEN - 1) / BCRB_RATE_MIN_DEN;
    localparam longint MIX_UNIT  = longint'(1) << BCRB_MIX_FRAC;
    localparam longint S_TOP     = (longint'(1) << (SW - 1)) - 1;
    localparam longint S_BOT     = -(longint'(1) << (SW - 1));

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;
    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_PATTERN} t_ready_mode;

    // One step of the opening sequence: a register write or an item,
    // the item optionally carrying a result that is known by inspection
    typedef struct packed {
        t_row_kind       kind;
        t_reg_idx        reg_sel;
        logic [31:0]     wval;
        logic [SW-1:0]   smp;
        logic            fixed;
        logic [SW-1:0]   want;
    } t_script_row;

    localparam int N_SCRIPT = 30;

    // Clock, reset and block ports
    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;   // [23:0] sample_in
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;         // [23:0] sample_out
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [BCRB_ADDR_W-1:0] paddr   = '0;
    logic [BCRB_APB_W-1:0]  pwdata  = '0;
    logic [BCRB_APB_W-1:0]  prdata;
    logic                   pready;

    // Predictor copy of the registers and state, at reset values
    logic [PF:0]          rate_reg  = 17'd65536;
    logic [4:0]           depth_reg = 5'd16;
    logic [11:0]          mix_reg   = 12'd1024;
    logic [PF:0]          phase_acc = 17'd65536;
    logic signed [SW-1:0] hist_newest = '0;
    logic signed [SW-1:0] hist_middle = '0;
    logic signed [SW-1:0] hist_oldest = '0;

    logic [SW-1:0] sample_out_due[$];
    logic [SW-1:0] prev_sample = '0;
    int            fail_cnt    = 0;

    // Receiver state
    int            results_seen = 0;
    int            hold_left    = 0;
    int            mode_left    = 0;
    int            pat_cnt      = 0;
    t_ready_mode   ready_mode   = RDY_ALWAYS;
    logic [SW-1:0] want_smp;

    // Opening sequence: dry-only rows pass the input unchanged
    t_script_row opening_script [N_SCRIPT] = '{
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'h000000, 1'b1, 24'h000000},
        '{ROW_WRITE, REG_WET_MIX,   32'd0,     24'h000000, 1'b0, 24'h000000},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'h7FFFFF, 1'b1, 24'h7FFFFF},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'h800000, 1'b1, 24'h800000},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'h000001, 1'b1, 24'h000001},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'h555555, 1'b1, 24'h555555},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'hAAAAAA, 1'b1, 24'hAAAAAA},
        // one-bit crush, wet only: quantiser hits +1.0 and saturates
        '{ROW_WRITE, REG_BIT_DEPTH, 32'd1,     24'h000000, 1'b0, 24'h000000},
        '{ROW_WRITE, REG_WET_MIX,   32'd2048,  24'h000000, 1'b0, 24'h000000},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'h7FFFFF, 1'b0, 24'h000000},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'h800000, 1'b0, 24'h000000},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'h3FFFFF, 1'b0, 24'h000000},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'hC00000, 1'b0, 24'h000000},
        // zero rate, zero depth and mix above two all clamp
        '{ROW_WRITE, REG_RATE_STEP, 32'd0,     24'h000000, 1'b0, 24'h000000},
        '{ROW_WRITE, REG_BIT_DEPTH, 32'd0,     24'h000000, 1'b0, 24'h000000},
        '{ROW_WRITE, REG_WET_MIX,   32'd4095,  24'h000000, 1'b0, 24'h000000},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'h7FFFFF, 1'b0, 24'h000000},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'h123456, 1'b0, 24'h000000},
        // rate above 1.0 and depth above 16 clamp, nearly dry mix
        '{ROW_WRITE, REG_RATE_STEP, 32'd131071, 24'h000000, 1'b0, 24'h000000},
        '{ROW_WRITE, REG_BIT_DEPTH, 32'd31,    24'h000000, 1'b0, 24'h000000},
        '{ROW_WRITE, REG_WET_MIX,   32'd1,     24'h000000, 1'b0, 24'h000000},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'h800000, 1'b0, 24'h000000},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'h7FFFFF, 1'b0, 24'h000000},
        // fractional phase, full depth, wet at 1.0 and dry at 0.5
        '{ROW_WRITE, REG_RATE_STEP, 32'd40000, 24'h000000, 1'b0, 24'h000000},
        '{ROW_WRITE, REG_BIT_DEPTH, 32'd16,    24'h000000, 1'b0, 24'h000000},
        '{ROW_WRITE, REG_WET_MIX,   32'd1536,  24'h000000, 1'b0, 24'h000000},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'hFFFFFF, 1'b0, 24'h000000},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'h000080, 1'b0, 24'h000000},
        '{ROW_ITEM,  REG_RATE_STEP, 32'd0,     24'h7FFF80, 1'b0, 24'h000000}
    };

    bitcrush_resample_bezier_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic longint clip_sample(input longint v);
        if (v > S_TOP) return S_TOP;
        if (v < S_BOT) return S_BOT;
        return v;
    endfunction

    // Crush, advance the phase, smooth the history and mix with the dry input
    function automatic logic [SW-1:0] crush_predict(input logic [SW-1:0] smp);
        longint x, v, q, rate, ph, t, u, c, b, a, cbl, bal, cb, m, wet, dry;
        int     depth, sh, ofs;
        x = longint'($signed(smp));
        depth = int'(depth_reg);
        if (depth < 1) depth = 1;
        if (depth > DEPTH_TOP) depth = DEPTH_TOP;
        sh  = SW - 1 - depth;
        ofs = SW - 2 - 2 * depth;
        v = x;
        if (ofs >= 0) v += longint'(1) << ofs;
        q = clip_sample((v >>> sh) <<< sh);

        rate = longint'(rate_reg);
        if (rate < RATE_FLOOR) rate = RATE_FLOOR;
        if (rate > PH_ONE) rate = PH_ONE;
        ph = longint'(phase_acc) + rate;
        if (ph > PH_ONE) begin
            ph -= PH_ONE;
            hist_oldest = hist_middle;
            hist_middle = hist_newest;
            hist_newest = SW'(q);
        end
        phase_acc = (PF + 1)'(ph);

        t = ph;
        u = PH_ONE - t;
        c = hist_oldest;
        b = hist_middle;
        a = hist_newest;
        cbl = (c * u + b * t + (longint'(1) << (PF - 1))) >>> PF;
        bal = (b * u + a * t + (longint'(1) << (PF - 1))) >>> PF;
        cb  = (b * PH_ONE + cbl * u + bal * t + (longint'(1) << PF)) >>> (PF + 1);

        m   = longint'(mix_reg);
        wet = (m > MIX_UNIT) ? MIX_UNIT : m;
        dry = (m >= 2 * MIX_UNIT) ? 0 : 2 * MIX_UNIT - m;
        if (dry > MIX_UNIT) dry = MIX_UNIT;
        return SW'(clip_sample((wet * cb + dry * x + BCRB_MIX_HALF) >>> BCRB_MIX_FRAC));
    endfunction

    // Mostly audio-like wandering, with extremes, near-zero and raw noise
    function automatic logic [SW-1:0] pick_sample();
        logic [SW-1:0] r;
        r = SW'($urandom());
        case ($urandom_range(0, 9))
            0: r = 24'h7FFFFF;
            1: r = 24'h800000;
            2: r = SW'($urandom_range(0, 511)) - 24'd256;
            3, 4, 5, 6: r = prev_sample + SW'($urandom_range(0, 131071)) - 24'd65536;
            default: ;
        endcase
        prev_sample = r;
        return r;
    endfunction

    // Offer one item and book its expected result once it is taken
    task automatic offer_sample(input logic [SW-1:0] smp, input logic fixed,
                                input logic [SW-1:0] want);
        logic [SW-1:0] pred;
        s_axis_tdata  <= DATA_W'(smp);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = crush_predict(smp);
        sample_out_due.push_back(fixed ? want : pred);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (sample_out_due.size() != 0) @(posedge i_clk);
    endtask

    // Two-phase register write; the predictor takes the value at the access edge
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BCRB_ADDR_W'(4 * idx);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_RATE_STEP: rate_reg  = val[PF:0];
            REG_BIT_DEPTH: depth_reg = val[4:0];
            REG_WET_MIX:   mix_reg   = val[11:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [31:0] rate, input logic [31:0] depth,
                                 input logic [31:0] mix);
        write_reg(REG_RATE_STEP, rate);
        write_reg(REG_BIT_DEPTH, depth);
        write_reg(REG_WET_MIX, mix);
    endtask

    // Random items in bursts, with random gaps and some gap-free stretches
    task automatic stream_samples(input int count);
        int burst, gap, k;
        burst = 0;
        for (k = 0; k < count; k++) begin
            if (burst == 0) begin
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
                if (gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            offer_sample(pick_sample(), 1'b0, '0);
            burst--;
        end
    endtask

    // Result check and receiver back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sample_out_due.size() == 0) begin
                $display("%0t: sample_out with none expected: expected none, got %0d",
                         $time, $signed(m_axis_tdata[SW-1:0]));
                fail_cnt++;
            end else begin
                want_smp = sample_out_due.pop_front();
                if (m_axis_tdata[SW-1:0] !== want_smp) begin
                    $display("%0t: sample_out mismatch: expected %0d, got %0d", $time,
                             $signed(want_smp), $signed(m_axis_tdata[SW-1:0]));
                    fail_cnt++;
                end
            end
            results_seen++;
            // long hold-off so the core backs up and stalls its input
            if (results_seen == 230 || results_seen == 530) hold_left = 400;
        end

        pat_cnt++;
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = t_ready_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(32, 300);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                RDY_ALWAYS:  m_axis_tready <= 1'b1;
                RDY_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
                RDY_MOSTLY:  m_axis_tready <= ($urandom_range(0, 7) != 0);
                default:     m_axis_tready <= (pat_cnt % 5) < 2;
            endcase
        end
    end

    // Stimulus: opening sequence, then phases of random items under varied settings
    initial begin : stimulus
        int row, ph;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < N_SCRIPT; row++) begin
            if (opening_script[row].kind == ROW_WRITE) begin
                settle_idle();
                write_reg(opening_script[row].reg_sel, opening_script[row].wval);
            end else begin
                offer_sample(opening_script[row].smp, opening_script[row].fixed,
                             opening_script[row].want);
            end
        end

        for (ph = 0; ph < 12; ph++) begin
            settle_idle();
            case (ph)
                0: apply_setting(32'd65536, 32'd1, 32'd2048);
                1: apply_setting(32'd33, 32'd16, 32'd1024);
                2: apply_setting(32'd0, 32'd0, 32'd4095);
                3: apply_setting(32'd131071, 32'd31, 32'd0);
                4: apply_setting(32'd32768, 32'd8, 32'd1536);
                5: apply_setting(32'd1000, 32'd4, 32'd1023);
                default: apply_setting(
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                : $urandom_range(33, 65536),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(1, 16),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(0, 2048));
            endcase
            stream_samples(62);
        end

        settle_idle();
        repeat (80) @(posedge i_clk);
        if (fail_cnt == 0 && sample_out_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ bitcrush_resample_bezier_core.f @@
+incdir+rtl/core
rtl/core/bcrb_pkg.sv
rtl/core/bcrb_front.sv
rtl/core/bcrb_sermul.sv
rtl/core/bitcrush_resample_bezier_core.sv
tb/sv/bitcrush_resample_bezier_core_test.sv
